// ----- hdl/zsn_pkg.sv -----
package zsn_pkg;

   // Default build of the normaliser
   localparam int MAX_LEN_DEF     = 64;
   localparam int SAMPLE_BITS_DEF = 16;

   // Result format: signed Q5.11
   localparam int Z_BITS    = 16;
   localparam int FRAC_BITS = 11;

   // Saturation limits on the result magnitude
   localparam logic [Z_BITS-1:0] Z_POS_LIM = 16'd32767;
   localparam logic [Z_BITS-1:0] Z_NEG_LIM = 16'd32768;

endpackage

// ----- hdl/z_score_normalizer.sv -----
// Steps: a sample request is taken while loading; after the last one the run goes
// through three setup steps, then per result through five operand steps, 16 bit
// trials (a candidate step and a compare step each), a saturating step and the
// output step; a zero or degenerate value skips the search and saturation.
// Throughput: one sample per cycle while loading, none again until the run is out.
// Reset (synchronous, active high) empties the run; the sample buffer is not cleared.
module z_score_normalizer import zsn_pkg::*; #(
   parameter int MAX_LEN     = MAX_LEN_DEF,
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic signed [SAMPLE_BITS-1:0] req_sample_value,
   input  logic                          req_is_last_sample,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [Z_BITS-1:0]      rsp_z_value,
   output logic                          rsp_last_of_run,
   output logic                          rsp_degenerate,
   output logic                          rsp_truncated
);

   localparam int AW    = $clog2(MAX_LEN);
   localparam int CW    = $clog2(MAX_LEN + 1);
   localparam int SUM_W = SAMPLE_BITS + CW;
   localparam int SQ_W  = 2 * SAMPLE_BITS + CW;
   localparam int NQ_W  = SQ_W + CW;
   localparam int L_W   = NQ_W + CW;
   localparam int A_W   = SAMPLE_BITS + 2 * CW + 1;
   localparam int A2_W  = 2 * A_W;
   localparam int SW    = L_W + 2 * Z_BITS + 2 * CW + 8;
   localparam int BW    = $clog2(Z_BITS);

   typedef enum logic [3:0] {
      ST_LOAD, ST_PREP1, ST_PREP2, ST_PREP3, ST_RD, ST_AX, ST_ASQ, ST_ARN,
      ST_INIT, ST_SC, ST_SU, ST_FIN, ST_OUT
   } state_type;

   state_type                   state_ff, state_in;
   logic [CW-1:0]               cnt_ff, cnt_in;
   logic signed [SUM_W-1:0]     sum_ff, sum_in;
   logic [SQ_W-1:0]             sq_ff, sq_in;
   logic                        ovf_ff, ovf_in;
   logic [NQ_W-1:0]             nq_ff, nq_in;
   logic [NQ_W-1:0]             ss_ff, ss_in;
   logic [NQ_W-1:0]             d_ff, d_in;
   logic [L_W-1:0]              l_ff, l_in;
   logic                        degen_ff, degen_in;
   logic [AW-1:0]               idx_ff, idx_in;
   logic signed [A_W-1:0]       a_ff, a_in;
   logic                        neg_ff, neg_in;
   logic [A2_W-1:0]             a2_ff, a2_in;
   logic signed [SW-1:0]        r_ff, r_in;
   logic signed [SW-1:0]        t_ff, t_in;
   logic signed [SW-1:0]        ps_ff, ps_in;
   logic signed [SW-1:0]        ls_ff, ls_in;
   logic signed [SW-1:0]        cand_ff, cand_in;
   logic [Z_BITS-1:0]           k_ff, k_in;
   logic [BW-1:0]               bit_ff, bit_in;
   logic signed [Z_BITS-1:0]    z_ff, z_in;
   logic                        last_ff, last_in;

   logic                          wr_en;
   logic [SAMPLE_BITS-1:0]        rd_data;
   logic signed [2*SAMPLE_BITS-1:0] x_sq;
   logic signed [2*SUM_W-1:0]     s_sq;
   logic signed [SAMPLE_BITS+CW:0] n_x;
   logic [A_W-1:0]                a_mag;
   logic signed [SW-1:0]          ps_acc;
   logic [Z_BITS-1:0]             lim;
   logic [Z_BITS-1:0]             k_sat;
   logic                          run_end;

   // Sample buffer
   zsn_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(MAX_LEN)) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (cnt_ff[AW-1:0]),
      .wr_data (req_sample_value),
      .rd_addr (idx_ff),
      .rd_data (rd_data)
   );

   assign req_ready       = (state_ff == ST_LOAD);
   assign rsp_valid       = (state_ff == ST_OUT);
   assign rsp_z_value     = z_ff;
   assign rsp_last_of_run = last_ff;
   assign rsp_degenerate  = degen_ff;
   assign rsp_truncated   = ovf_ff;

   assign wr_en   = req_valid && req_ready && (cnt_ff < CW'(MAX_LEN));
   assign x_sq    = req_sample_value * req_sample_value;
   assign s_sq    = sum_ff * sum_ff;
   assign n_x     = $signed({1'b0, cnt_ff}) * $signed(rd_data);
   assign a_mag   = a_ff[A_W-1] ? A_W'(-a_ff) : A_W'(a_ff);
   assign ps_acc  = (cand_ff <= r_ff) ? (ps_ff + (ls_ff <<< 1)) : ps_ff;
   assign lim     = neg_ff ? Z_NEG_LIM : Z_POS_LIM;
   assign k_sat   = (k_ff > lim) ? lim : k_ff;
   assign run_end = (CW'(idx_ff) == cnt_ff - CW'(1));

   // Sequencer: load, run setup, then per sample operands and bit search
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      sum_in   = sum_ff;
      sq_in    = sq_ff;
      ovf_in   = ovf_ff;
      nq_in    = nq_ff;
      ss_in    = ss_ff;
      d_in     = d_ff;
      l_in     = l_ff;
      degen_in = degen_ff;
      idx_in   = idx_ff;
      a_in     = a_ff;
      neg_in   = neg_ff;
      a2_in    = a2_ff;
      r_in     = r_ff;
      t_in     = t_ff;
      ps_in    = ps_ff;
      ls_in    = ls_ff;
      cand_in  = cand_ff;
      k_in     = k_ff;
      bit_in   = bit_ff;
      z_in     = z_ff;
      last_in  = last_ff;
      unique case (state_ff)
         ST_LOAD: begin
            if (req_valid) begin
               if (wr_en) begin
                  cnt_in = cnt_ff + CW'(1);
                  sum_in = sum_ff + SUM_W'(req_sample_value);
                  sq_in  = sq_ff + SQ_W'($unsigned(x_sq));
               end else begin
                  ovf_in = 1'b1;
               end
               if (req_is_last_sample) begin
                  state_in = ST_PREP1;
               end
            end
         end
         ST_PREP1: begin
            nq_in    = NQ_W'(cnt_ff * sq_ff);
            ss_in    = NQ_W'($unsigned(s_sq));
            state_in = ST_PREP2;
         end
         ST_PREP2: begin
            d_in     = nq_ff - ss_ff;
            state_in = ST_PREP3;
         end
         ST_PREP3: begin
            l_in     = L_W'(cnt_ff * d_ff);
            degen_in = (cnt_ff < CW'(2)) || (d_ff == '0);
            idx_in   = '0;
            state_in = ST_RD;
         end
         ST_RD: begin
            state_in = ST_AX;
         end
         ST_AX: begin
            a_in     = A_W'(n_x) - A_W'(sum_ff);
            state_in = ST_ASQ;
         end
         ST_ASQ: begin
            neg_in = a_ff[A_W-1];
            a2_in  = A2_W'(a_mag * a_mag);
            if (degen_ff || (a_ff == '0)) begin
               z_in     = '0;
               last_in  = run_end;
               state_in = ST_OUT;
            end else begin
               state_in = ST_ARN;
            end
         end
         ST_ARN: begin
            r_in     = SW'(a2_ff * (cnt_ff - CW'(1))) <<< (2 * FRAC_BITS + 2);
            state_in = ST_INIT;
         end
         ST_INIT: begin
            t_in     = SW'(l_ff);
            ps_in    = -(SW'(l_ff) <<< (Z_BITS + 1));
            ls_in    = SW'(l_ff) <<< (2 * Z_BITS);
            k_in     = '0;
            bit_in   = BW'(Z_BITS - 1);
            state_in = ST_SC;
         end
         ST_SC: begin
            cand_in  = t_ff + ps_ff + ls_ff;
            state_in = ST_SU;
         end
         ST_SU: begin
            // keep the trial bit when the scaled square stays within bound
            if (cand_ff <= r_ff) begin
               t_in         = cand_ff;
               k_in[bit_ff] = 1'b1;
            end
            ps_in = ps_acc >>> 1;
            ls_in = ls_ff >>> 2;
            if (bit_ff == '0) begin
               state_in = ST_FIN;
            end else begin
               bit_in   = bit_ff - BW'(1);
               state_in = ST_SC;
            end
         end
         ST_FIN: begin
            z_in     = neg_ff ? $signed(-k_sat) : $signed(k_sat);
            last_in  = run_end;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (rsp_ready) begin
               if (last_ff) begin
                  cnt_in   = '0;
                  sum_in   = '0;
                  sq_in    = '0;
                  ovf_in   = 1'b0;
                  state_in = ST_LOAD;
               end else begin
                  idx_in   = idx_ff + AW'(1);
                  state_in = ST_RD;
               end
            end
         end
         default: state_in = ST_LOAD;
      endcase
   end

   // Hold state and datapath registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
         cnt_ff   <= '0;
         sum_ff   <= '0;
         sq_ff    <= '0;
         ovf_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         sum_ff   <= sum_in;
         sq_ff    <= sq_in;
         ovf_ff   <= ovf_in;
      end
      nq_ff    <= nq_in;
      ss_ff    <= ss_in;
      d_ff     <= d_in;
      l_ff     <= l_in;
      degen_ff <= degen_in;
      idx_ff   <= idx_in;
      a_ff     <= a_in;
      neg_ff   <= neg_in;
      a2_ff    <= a2_in;
      r_ff     <= r_in;
      t_ff     <= t_in;
      ps_ff    <= ps_in;
      ls_ff    <= ls_in;
      cand_ff  <= cand_in;
      k_ff     <= k_in;
      bit_ff   <= bit_in;
      z_ff     <= z_in;
      last_ff  <= last_in;
   end

endmodule

// ----- hdl/zsn_ram.sv -----
module zsn_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write port, registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

// ----- hdl/zsn_checker.sv -----
module zsn_checker import zsn_pkg::*; (
   input logic              clock,
   input logic              reset,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [Z_BITS-1:0] rsp_z_value,
   input logic              rsp_last_of_run,
   input logic              rsp_degenerate
);

   // Never take a request while a result is on offer
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("request taken while result pending");

   // Hold a stalled result
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_z_value))
      else $error("stalled result changed");

   // Degenerate runs give zero values
   a_degen_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_degenerate |-> rsp_z_value == '0)
      else $error("degenerate result not zero");

   // Return to loading after the final result of a run
   a_run_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_last_of_run |=> req_ready && !rsp_valid)
      else $error("block not idle after run");

   // Come out of reset ready to load
   a_reset: assert property (@(posedge clock)
      $past(reset) |-> req_ready && !rsp_valid)
      else $error("not ready after reset");

endmodule

bind z_score_normalizer zsn_checker u_zsn_checker (
   .clock           (clock),
   .reset           (reset),
   .req_ready       (req_ready),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_z_value     (rsp_z_value),
   .rsp_last_of_run (rsp_last_of_run),
   .rsp_degenerate  (rsp_degenerate)
);

// ----- tb/z_score_normalizer_test.sv -----
`timescale 1ns / 1ps

module z_score_normalizer_test import zsn_pkg::*; ();

   localparam int DEPTH = MAX_LEN_DEF;

   typedef struct packed {
      logic signed [Z_BITS-1:0] z;
      logic                     last;
      logic                     degen;
      logic                     trunc;
   } z_result_type;

   typedef struct {
      logic signed [15:0] sample;
      logic               last;
      logic               typed;   // expected result forced to zero, degenerate, not truncated; not predicted
   } sample_row_type;

   logic clock, reset;
   logic req_valid, req_ready, req_is_last_sample;
   logic signed [15:0] req_sample_value;
   logic rsp_valid, rsp_ready, rsp_last_of_run, rsp_degenerate, rsp_truncated;
   logic signed [Z_BITS-1:0] rsp_z_value;

   z_score_normalizer dut (.*);

   // predictor state
   logic signed [15:0] held_samples[DEPTH];
   int unsigned        held_count;
   longint             sum_x;
   longint             sum_xx;
   bit                 dropped_seen;

   z_result_type expected_z[$];
   int           errors;
   int           sent;
   bit           quiet;

   always begin
      clock = 1'b1; #1;
      clock = 1'b0; #1;
   end

   // largest k <= lim with (2k-1)^2 * n * D <= 4 * A^2 * (n-1) * 2^22
   function automatic int unsigned round_mag(longint unsigned amag, longint unsigned n,
                                             longint unsigned d, int unsigned lim);
      bit [127:0]      rhs, lhs;
      longint unsigned odd;
      int unsigned     lo, hi, mid;
      rhs = (128'(amag) * 128'(amag) * 128'(n - 1)) << (2 * FRAC_BITS + 2);
      lo = 0;
      hi = lim;
      while (lo < hi) begin
         mid = (lo + hi + 1) / 2;
         odd = 2 * longint'(mid) - 1;
         lhs = 128'(odd) * 128'(odd) * 128'(n) * 128'(d);
         if (lhs <= rhs) lo = mid;
         else hi = mid - 1;
      end
      return lo;
   endfunction

   // take one accepted request; on the last one queue the normalised run
   task automatic normalise_sample(logic signed [15:0] x, logic last, logic typed);
      longint       n, d, a;
      bit           degen;
      z_result_type r;
      if (held_count < DEPTH) begin
         held_samples[held_count] = x;
         held_count++;
         sum_x  += x;
         sum_xx += longint'(x) * longint'(x);
      end else begin
         dropped_seen = 1'b1;
      end
      if (!last) return;
      n = held_count;
      d = n * sum_xx - sum_x * sum_x;
      degen = (n < 2) || (d == 0);
      for (int i = 0; i < held_count; i++) begin
         a = n * longint'(held_samples[i]) - sum_x;
         r.z = '0;
         if (!degen && a != 0) begin
            if (a < 0) r.z = Z_BITS'(-round_mag(-a, n, d, Z_NEG_LIM));
            else r.z = Z_BITS'(round_mag(a, n, d, Z_POS_LIM));
         end
         r.last  = (i + 1 == held_count);
         r.degen = degen;
         r.trunc = dropped_seen;
         if (typed) begin
            r.z = '0;
            r.degen = 1'b1;
            r.trunc = 1'b0;
         end
         expected_z = {expected_z, r};
      end
      held_count = 0;
      sum_x = 0;
      sum_xx = 0;
      dropped_seen = 1'b0;
   endtask

   // drive one request and hold it until taken
   task automatic send_sample(logic signed [15:0] x, logic last, logic typed);
      int gap;
      if (!quiet && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 8);
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid = 1'b1;
      req_sample_value = x;
      req_is_last_sample = last;
      forever begin
         @(posedge clock);
         if (req_ready) break;
      end
      normalise_sample(x, last, typed);
      sent++;
      @(negedge clock);
   endtask

   task automatic send_run(int len, int kind);
      logic signed [15:0] base, x;
      base = 16'($urandom);
      for (int i = 0; i < len; i++) begin
         case (kind)
            0: x = base;                                      // constant run
            1: x = base + 16'($urandom_range(0, 3));          // narrow spread
            default: x = 16'($urandom);                       // full range
         endcase
         send_sample(x, i == len - 1, 1'b0);
      end
   endtask

   // result checker
   always @(posedge clock) begin
      z_result_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_z.size() == 0) begin
            $display("%0t: unexpected result z=%0d", $time, rsp_z_value);
            errors++;
         end else begin
            e = expected_z.pop_front();
            if (rsp_z_value !== e.z || rsp_last_of_run !== e.last ||
                rsp_degenerate !== e.degen || rsp_truncated !== e.trunc) begin
               $display("%0t: expected z=%0d last=%0b degen=%0b trunc=%0b, %s",
                        $time, e.z, e.last, e.degen, e.trunc, "got");
               $display("%0t:    actual z=%0d last=%0b degen=%0b trunc=%0b",
                        $time, rsp_z_value, rsp_last_of_run, rsp_degenerate,
                        rsp_truncated);
               errors++;
            end
         end
      end
   end

   // receiver stalls in bursts
   initial begin
      int len;
      rsp_ready = 1'b0;
      forever begin
         len = $urandom_range(1, 8);
         rsp_ready = quiet || ($urandom_range(0, 2) != 0);
         repeat (len) @(negedge clock);
      end
   end

   initial begin
      #2_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

   sample_row_type rows[19] = '{
      '{-16'sd32768, 1'b1, 1'b1},                              // single sample
      '{16'sd5, 1'b0, 1'b1}, '{16'sd5, 1'b1, 1'b1},              // zero deviation
      '{-16'sd32768, 1'b0, 1'b0}, '{16'sd32767, 1'b1, 1'b0},    // extremes
      '{16'sd32767, 1'b0, 1'b0}, '{16'sd32767, 1'b0, 1'b0}, '{-16'sd32768, 1'b1, 1'b0},
      '{16'sd1, 1'b0, 1'b0}, '{16'sd2, 1'b0, 1'b0}, '{16'sd3, 1'b1, 1'b0},
      '{16'sd0, 1'b0, 1'b0}, '{16'sd0, 1'b0, 1'b0}, '{16'sd0, 1'b0, 1'b0},
      '{-16'sd1, 1'b1, 1'b0},
      '{-16'sd7, 1'b0, 1'b1}, '{-16'sd7, 1'b0, 1'b1}, '{-16'sd7, 1'b0, 1'b1},
      '{-16'sd7, 1'b1, 1'b1}
   };

   initial begin
      int kind;
      errors = 0;
      sent = 0;
      quiet = 1'b0;
      held_count = 0;
      sum_x = 0;
      sum_xx = 0;
      dropped_seen = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_sample_value = '0;
      req_is_last_sample = 1'b0;
      repeat (6) @(negedge clock);
      reset = 1'b0;

      // directed rows
      foreach (rows[i]) send_sample(rows[i].sample, rows[i].last, rows[i].typed);

      // hold off until the directed runs have all drained
      req_valid = 1'b0;
      while (expected_z.size() != 0) @(negedge clock);

      // overflowing run, including a dropped last sample
      send_run($urandom_range(65, 68), 2);

      // random runs
      while (sent < 200) begin
         if (sent > 120 && !quiet) begin
            quiet = 1'b1;
            send_run(DEPTH + 1, 1);
         end
         kind = $urandom_range(0, 9);
         if (kind == 0) send_run(1, 2);
         else if (kind == 1) send_run($urandom_range(2, 6), 0);
         else if (kind < 4) send_run($urandom_range(2, 16), 1);
         else send_run($urandom_range(2, 16), 2);
      end
      req_valid = 1'b0;

      // drain and let any stray result show up
      while (expected_z.size() != 0) @(negedge clock);
      repeat (100) @(negedge clock);
      if (errors == 0) $display("RESULT: OK");
      else $display("RESULT: ERROR");
      $finish;
   end

endmodule

// ----- filelist.f -----
hdl/zsn_pkg.sv
hdl/zsn_ram.sv
hdl/z_score_normalizer.sv
hdl/zsn_checker.sv
tb/z_score_normalizer_test.sv
